FILE: rtl/tgc_pkg.sv
// Shared types, constants and pixel helper functions of the cell pixel generator.
`default_nettype none
package tgc_pkg;

  localparam int CELL_ROWS_DEFAULT   = 16;
  localparam int GLYPH_COUNT_DEFAULT = 256;
  localparam int STORE_DEPTH         = 4096;
  localparam int STORE_AW            = 12;
  localparam int QUEUE_DEPTH         = 4;

  localparam int S_TDATA_W  = 64;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [1:0] PIX_NORMAL = 2'd1;
  localparam logic [1:0] PIX_BRIGHT = 2'd2;
  localparam logic [4:0] COUNT_NARROW = 5'd8;
  localparam logic [4:0] COUNT_WIDE   = 5'd16;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_FONT = 2'd1,
    FUNC_TEXT = 2'd2,
    FUNC_GFX  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CFG_CURSOR_ENABLE  = 3'd0,
    CFG_CURSOR_STEADY  = 3'd1,
    CFG_CURSOR_TOP     = 3'd2,
    CFG_CURSOR_BOTTOM  = 3'd3,
    CFG_CURSOR_ADDRESS = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    CMD_FONT,
    CMD_TEXT,
    CMD_GFX
  } cmd_kind_t;

  typedef struct packed {
    logic        cursor_enable;
    logic        cursor_steady;
    logic [4:0]  cursor_top;
    logic [4:0]  cursor_bottom;
    logic [18:0] cursor_address;
  } cfg_t;

  // One classified item travelling from front to back.
  typedef struct packed {
    cmd_kind_t           kind;
    logic [STORE_AW-1:0] addr;     // font write address or glyph read address
    logic [7:0]          data;     // font byte or graphics pattern
    logic                row_ok;   // row lies inside the cell
    logic                blank;
    logic                reverse;
    logic                bright;
    logic                wide;
    logic                show;     // cursor covers this row
  } cmd_t;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // Bit i of bits becomes pixel i (pixels 2i and 2i+1 when wide).
  function automatic logic [31:0] spread(input logic [7:0] bits, input logic [1:0] code,
                                         input logic wide);
    logic [31:0] out;
    out = '0;
    for (int i = 0; i < 8; i++) begin
      if (bits[i]) begin
        if (wide) begin
          out[4*i +: 2]     = code;
          out[4*i + 2 +: 2] = code;
        end else begin
          out[2*i +: 2] = code;
        end
      end
    end
    return out;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tgc_front.sv
// Front end: accepts items, keeps the blink counter and classifies each item into a command.
`default_nettype none
module tgc_front
  import tgc_pkg::*;
#(
  parameter int CELL_ROWS   = CELL_ROWS_DEFAULT,
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  input  wire logic [S_TUSER_W-1:0] s_tuser,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output cmd_t                      push_cmd
);

  localparam logic [4:0] ROWS   = 5'(CELL_ROWS);
  localparam logic [8:0] GLYPHS = 9'(GLYPH_COUNT);

  logic [4:0]  blink_counter;
  logic        blink_phase;
  func_t       func;
  logic [11:0] font_index;
  logic [7:0]  data_byte;
  logic [7:0]  char_code;
  logic [7:0]  attribute;
  logic [3:0]  cell_row;
  logic        wide_mode;
  logic [18:0] cell_address;
  logic [7:0]  code;
  logic [4:0]  bottom;
  logic        cursor_hit;

  assign func         = func_t'(s_tuser);
  assign font_index   = s_tdata[11:0];
  assign data_byte    = s_tdata[19:12];
  assign char_code    = s_tdata[27:20];
  assign attribute    = s_tdata[35:28];
  assign cell_row     = s_tdata[39:36];
  assign wide_mode    = s_tdata[40];
  assign cell_address = s_tdata[59:41];

  assign s_tready    = push_ready;
  assign blink_phase = blink_counter[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_counter <= '0;
    end else if (s_tvalid && s_tready && func == FUNC_TICK) begin
      blink_counter <= blink_counter + 5'd1;
    end
  end

  // Code modulo glyph count: code is below twice the count, one subtract does it.
  assign code   = ({1'b0, char_code} >= GLYPHS) ? 8'({1'b0, char_code} - GLYPHS) : char_code;
  assign bottom = (cfg.cursor_bottom > ROWS) ? ROWS : cfg.cursor_bottom;

  assign cursor_hit = cfg.cursor_enable && (cfg.cursor_steady || !blink_phase)
                   && (cell_address == cfg.cursor_address)
                   && ({1'b0, cell_row} >= cfg.cursor_top)
                   && ({1'b0, cell_row} < bottom);

  always_comb begin
    push_cmd         = '0;
    push_cmd.kind    = CMD_GFX;
    push_cmd.data    = data_byte;
    push_cmd.wide    = wide_mode;
    push_valid       = 1'b0;
    unique case (func)
      FUNC_TICK: begin
        push_valid = 1'b0;
      end
      FUNC_FONT: begin
        push_valid    = s_tvalid;
        push_cmd.kind = CMD_FONT;
        push_cmd.addr = font_index;
      end
      FUNC_TEXT: begin
        push_valid       = s_tvalid;
        push_cmd.kind    = CMD_TEXT;
        push_cmd.addr    = {code, cell_row};
        push_cmd.row_ok  = {1'b0, cell_row} < ROWS;
        push_cmd.blank   = attribute[6] || (attribute[7] && blink_phase);
        push_cmd.reverse = attribute[3];
        push_cmd.bright  = attribute[2];
        push_cmd.show    = cursor_hit;
      end
      FUNC_GFX: begin
        push_valid    = s_tvalid;
        push_cmd.kind = CMD_GFX;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/tgc_queue.sv
// Short command queue between front and back.
`default_nettype none
module tgc_queue
  import tgc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != FULL;
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tgc_back.sv
// Back end: glyph store, pattern shaping and the registered result stage.
`default_nettype none
module tgc_back
  import tgc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire cmd_t                 cmd,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata
);

  logic [7:0]  glyph_mem [STORE_DEPTH];
  logic [7:0]  rd_data;
  logic        s1_valid;
  cmd_t        s1_cmd;
  logic        out_free;
  logic        take;
  logic [7:0]  pat;
  logic [31:0] pixels;
  logic [4:0]  count;

  assign out_free  = !m_tvalid || m_tready;
  assign cmd_ready = !s1_valid || out_free;
  assign take      = cmd_valid && cmd_ready;

  // Glyph store: one write or one read per cycle when a command is taken, read data registered.
  always_ff @(posedge clk) begin
    if (take && cmd.kind == CMD_FONT) begin
      glyph_mem[cmd.addr] <= cmd.data;
    end
    if (take && cmd.kind == CMD_TEXT) begin
      rd_data <= glyph_mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_ready) begin
      s1_valid <= cmd_valid && cmd.kind != CMD_FONT;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_cmd <= cmd;
    end
  end

  always_comb begin
    pat    = '0;
    pixels = '0;
    case (s1_cmd.kind)
      CMD_TEXT: begin
        pat = s1_cmd.row_ok ? rd_data : 8'h00;
        if (s1_cmd.blank) begin
          pat = 8'h00;
        end
        if (s1_cmd.reverse) begin
          pat = ~pat;
        end
        pixels = spread(pat, s1_cmd.bright ? PIX_BRIGHT : PIX_NORMAL, s1_cmd.wide);
        if (s1_cmd.show) begin
          pixels = spread(8'hff, PIX_NORMAL, s1_cmd.wide);
        end
      end
      default: begin
        pixels = spread(reverse8(s1_cmd.data), PIX_NORMAL, s1_cmd.wide);
      end
    endcase
    count = s1_cmd.wide ? COUNT_WIDE : COUNT_NARROW;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      m_tdata <= {3'b000, count, pixels};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/text_graphics_cell_pixel_generator.sv
// Top level of the text and graphics cell pixel generator.
`default_nettype none
// One transfer in, at most one transfer out. tuser carries the item kind: frame tick,
// font byte write, text cell or graphics byte. Ticks and font writes give no result;
// text cells and graphics bytes each give one row of 8 (16 in wide mode) two-bit
// pixel codes. The block takes one item per cycle while the output is not stalled.
// An accepted item is written into the command queue; the back end then takes it
// and reads the glyph store, and the output register is loaded from that stage. The
// queue and the output register let input and output stall independently. The
// glyph store has no reset and no clearing pass; a text cell may only read glyph
// rows already written.
// Configuration writes must be made while the block is idle.
module text_graphics_cell_pixel_generator
  import tgc_pkg::*;
#(
  parameter int CELL_ROWS   = CELL_ROWS_DEFAULT,   // 8 to 16
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEFAULT  // 128 to 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // config write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // s_tdata from bit 0: font_index[11:0], data_byte[19:12], char_code[27:20],
  // attribute[35:28], cell_row[39:36], wide_mode[40], cell_address[59:41], zero pad
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  // s_tuser: func[1:0]
  input  wire logic [S_TUSER_W-1:0]  s_tuser,
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // m_tdata from bit 0: pixels[31:0], pixel_count[36:32], zero pad
  output logic [M_TDATA_W-1:0]       m_tdata
);

  cfg_t cfg;
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // Cursor registers; indices beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CURSOR_ENABLE:  cfg.cursor_enable  <= cfg_data[0];
        CFG_CURSOR_STEADY:  cfg.cursor_steady  <= cfg_data[0];
        CFG_CURSOR_TOP:     cfg.cursor_top     <= cfg_data[4:0];
        CFG_CURSOR_BOTTOM:  cfg.cursor_bottom  <= cfg_data[4:0];
        CFG_CURSOR_ADDRESS: cfg.cursor_address <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: decode, blink counter, cursor compare.
  tgc_front #(
    .CELL_ROWS   (CELL_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Queue of classified commands.
  tgc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Back: glyph store and pixel row assembly.
  tgc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire
